FILE: design/bpd_pkg.sv
// Shared types, constants and the keyword table of the BASIC program detokenizer.
package bpd_pkg;

   localparam int unsigned KEYWORD_COUNT_DEF = 76;
   localparam int unsigned ROM_ENTRIES = 76;
   localparam logic [7:0] TOKEN_BASE = 8'h80;
   localparam int unsigned KW_MAX_LEN = 7;

   typedef enum logic [3:0] {
      PH_LOAD_LO = 4'd0,
      PH_LOAD_HI = 4'd1,
      PH_LINK_LO = 4'd2,
      PH_LINK_HI = 4'd3,
      PH_NUM_LO  = 4'd4,
      PH_NUM_HI  = 4'd5,
      PH_TEXT    = 4'd6,
      PH_SKIP    = 4'd7,
      PH_HALT    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_CHAR     = 3'd0,
      KIND_START    = 3'd1,
      KIND_END      = 3'd2,
      KIND_PROG_END = 3'd3,
      KIND_BACK_ERR = 3'd4
   } kind_type;

   typedef enum logic {
      CT_IDLE = 1'b0,
      CT_EMIT = 1'b1
   } ctrl_state_type;

   // What one accepted byte produces: no result, a single result, an end/error pair, or a keyword.
   typedef struct packed {
      logic        kw;
      logic [6:0]  kw_idx;
      logic [2:0]  count;
      kind_type    kind0;
      logic [7:0]  char0;
      logic [15:0] num0;
   } desc_type;

   typedef struct packed {
      logic       accept;
      logic       out_load;
      logic       use_latched;
      logic [2:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [2:0] now_count;
      logic [2:0] lat_count;
      logic       out_free;
   } stat_type;

   // Keyword text, right-aligned with zero bytes in front.
   function automatic logic [8*KW_MAX_LEN-1:0] keyword_text(input logic [6:0] idx);
      logic [8*KW_MAX_LEN-1:0] text;
      text = '0;
      case (idx)
         7'd0:  text = "END";
         7'd1:  text = "FOR";
         7'd2:  text = "NEXT";
         7'd3:  text = "DATA";
         7'd4:  text = "INPUT#";
         7'd5:  text = "INPUT";
         7'd6:  text = "DIM";
         7'd7:  text = "READ";
         7'd8:  text = "LET";
         7'd9:  text = "GOTO";
         7'd10: text = "RUN";
         7'd11: text = "IF";
         7'd12: text = "RESTORE";
         7'd13: text = "GOSUB";
         7'd14: text = "RETURN";
         7'd15: text = "REM";
         7'd16: text = "STOP";
         7'd17: text = "ON";
         7'd18: text = "WAIT";
         7'd19: text = "LOAD";
         7'd20: text = "SAVE";
         7'd21: text = "VERIFY";
         7'd22: text = "DEF";
         7'd23: text = "POKE";
         7'd24: text = "PRINT#";
         7'd25: text = "PRINT";
         7'd26: text = "CONT";
         7'd27: text = "LIST";
         7'd28: text = "CLR";
         7'd29: text = "CMD";
         7'd30: text = "SYS";
         7'd31: text = "OPEN";
         7'd32: text = "CLOSE";
         7'd33: text = "GET";
         7'd34: text = "NEW";
         7'd35: text = "TAB(";
         7'd36: text = "TO";
         7'd37: text = "FN";
         7'd38: text = "SPC(";
         7'd39: text = "THEN";
         7'd40: text = "NOT";
         7'd41: text = "STEP";
         7'd42: text = "+";
         7'd43: text = "-";
         7'd44: text = "*";
         7'd45: text = "/";
         7'd46: text = "^";
         7'd47: text = "AND";
         7'd48: text = "OR";
         7'd49: text = ">";
         7'd50: text = "=";
         7'd51: text = "<";
         7'd52: text = "SGN";
         7'd53: text = "INT";
         7'd54: text = "ABS";
         7'd55: text = "USR";
         7'd56: text = "FRE";
         7'd57: text = "POS";
         7'd58: text = "SQR";
         7'd59: text = "RND";
         7'd60: text = "LOG";
         7'd61: text = "EXP";
         7'd62: text = "COS";
         7'd63: text = "SIN";
         7'd64: text = "TAN";
         7'd65: text = "ATN";
         7'd66: text = "PEEK";
         7'd67: text = "LEN";
         7'd68: text = "STR$";
         7'd69: text = "VAL";
         7'd70: text = "ASC";
         7'd71: text = "CHR$";
         7'd72: text = "LEFT$";
         7'd73: text = "RIGHT$";
         7'd74: text = "MID$";
         7'd75: text = "GO";
         default: text = '0;
      endcase
      return text;
   endfunction

   // Number of characters is the number of nonzero bytes in the text.
   function automatic logic [2:0] keyword_len(input logic [8*KW_MAX_LEN-1:0] text);
      logic [2:0] len;
      len = '0;
      for (int i = 0; i < KW_MAX_LEN; i++) begin
         if (text[8*i +: 8] != 8'd0) begin
            len = len + 3'd1;
         end
      end
      return len;
   endfunction

endpackage

FILE: design/bpd_req_if.sv
// Input channel: one program file byte per beat.
interface bpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink (input valid, input data_byte, input first, output ready);
endinterface

FILE: design/bpd_rsp_if.sv
// Result channel: one detokenized result per beat.
interface bpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  character;
   logic [15:0] line_number;
   logic        last;

   modport source (output valid, output kind, output character, output line_number,
                   output last, input ready);
   modport sink (input valid, input kind, input character, input line_number,
                 input last, output ready);
endinterface

FILE: design/bpd_dp.sv
// Datapath: file parser state, result descriptor and registered result beat.
module bpd_dp #(
   parameter int unsigned KEYWORD_COUNT = bpd_pkg::KEYWORD_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_data_byte,
   input  logic              req_first,
   input  logic              rsp_ready,
   input  bpd_pkg::cmd_type  cmd,
   output bpd_pkg::stat_type stat,
   output logic              rsp_valid,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_character,
   output logic [15:0]       rsp_line_number,
   output logic              rsp_last
);

   bpd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] load_ff, load_in;
   logic [15:0] link_ff, link_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  hold_ff, hold_in;
   bpd_pkg::desc_type desc_ff, desc_now, sel;

   bpd_pkg::phase_type eff_phase, cur_phase;
   logic [15:0] eff_load, eff_link, eff_pos, word, link_target;
   logic [7:0]  eff_hold;
   logic [6:0]  tok_idx;
   logic        is_kw;
   logic [8*bpd_pkg::KW_MAX_LEN-1:0] now_text, sel_text;
   logic [2:0]  sel_len, shift;

   bpd_pkg::kind_type res_kind, kind_ff;
   logic [7:0]  res_char, char_ff;
   logic [15:0] res_num, num_ff;
   logic        res_last, last_ff, valid_ff;

   assign tok_idx = req_data_byte[6:0];
   assign is_kw = (req_data_byte >= bpd_pkg::TOKEN_BASE)
                  && ({1'b0, tok_idx} < 8'(KEYWORD_COUNT))
                  && ({1'b0, tok_idx} < 8'(bpd_pkg::ROM_ENTRIES));
   assign now_text = bpd_pkg::keyword_text(tok_idx);

   // Next parser state and the descriptor of what the incoming byte produces.
   always_comb begin
      eff_phase = req_first ? bpd_pkg::PH_LOAD_LO : phase_ff;
      eff_load  = req_first ? 16'd0 : load_ff;
      eff_link  = req_first ? 16'd0 : link_ff;
      eff_pos   = req_first ? 16'd0 : pos_ff;
      eff_hold  = req_first ? 8'd0 : hold_ff;
      cur_phase = eff_phase;
      if (eff_phase == bpd_pkg::PH_SKIP && eff_pos == eff_link) begin
         cur_phase = bpd_pkg::PH_LINK_LO;
      end
      word = {req_data_byte, eff_hold};
      link_target = word - eff_load + 16'd2;

      phase_in = cur_phase;
      load_in  = eff_load;
      link_in  = eff_link;
      hold_in  = eff_hold;
      pos_in   = eff_pos + 16'd1;
      desc_now = '0;

      case (cur_phase)
         bpd_pkg::PH_LOAD_LO: begin
            hold_in = req_data_byte;
            phase_in = bpd_pkg::PH_LOAD_HI;
         end
         bpd_pkg::PH_LINK_LO: begin
            hold_in = req_data_byte;
            phase_in = bpd_pkg::PH_LINK_HI;
         end
         bpd_pkg::PH_NUM_LO: begin
            hold_in = req_data_byte;
            phase_in = bpd_pkg::PH_NUM_HI;
         end
         bpd_pkg::PH_LOAD_HI: begin
            load_in = word;
            phase_in = bpd_pkg::PH_LINK_LO;
         end
         bpd_pkg::PH_LINK_HI: begin
            if (word == 16'd0) begin
               desc_now.count = 3'd1;
               desc_now.kind0 = bpd_pkg::KIND_PROG_END;
               phase_in = bpd_pkg::PH_HALT;
            end else begin
               link_in = link_target;
               phase_in = bpd_pkg::PH_NUM_LO;
            end
         end
         bpd_pkg::PH_NUM_HI: begin
            desc_now.count = 3'd1;
            desc_now.kind0 = bpd_pkg::KIND_START;
            desc_now.num0 = word;
            phase_in = bpd_pkg::PH_TEXT;
         end
         bpd_pkg::PH_TEXT: begin
            if (req_data_byte == 8'd0) begin
               desc_now.kind0 = bpd_pkg::KIND_END;
               // A link that does not point past this zero byte is a backward link.
               if (eff_link <= eff_pos) begin
                  desc_now.count = 3'd2;
                  phase_in = bpd_pkg::PH_HALT;
               end else begin
                  desc_now.count = 3'd1;
                  phase_in = bpd_pkg::PH_SKIP;
               end
            end else if (is_kw) begin
               desc_now.kw = 1'b1;
               desc_now.kw_idx = tok_idx;
               desc_now.count = bpd_pkg::keyword_len(now_text);
            end else begin
               desc_now.count = 3'd1;
               desc_now.kind0 = bpd_pkg::KIND_CHAR;
               desc_now.char0 = req_data_byte;
            end
         end
         default: begin
         end
      endcase
   end

   // Result number cmd.idx of the selected descriptor.
   always_comb begin
      sel = cmd.use_latched ? desc_ff : desc_now;
      sel_text = bpd_pkg::keyword_text(sel.kw_idx);
      sel_len = bpd_pkg::keyword_len(sel_text);
      shift = sel_len - 3'd1 - cmd.idx;
      res_kind = bpd_pkg::KIND_CHAR;
      res_char = 8'd0;
      res_num = 16'd0;
      if (sel.kw) begin
         res_char = 8'(sel_text >> {shift, 3'b000});
      end else if (cmd.idx == 3'd0) begin
         res_kind = sel.kind0;
         res_char = sel.char0;
         res_num = sel.num0;
      end else begin
         res_kind = bpd_pkg::KIND_BACK_ERR;
      end
      res_last = (cmd.idx == sel.count - 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bpd_pkg::PH_LOAD_LO;
         load_ff <= '0;
         link_ff <= '0;
         pos_ff <= '0;
         hold_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            phase_ff <= phase_in;
            load_ff <= load_in;
            link_ff <= link_in;
            pos_ff <= pos_in;
            hold_ff <= hold_in;
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         desc_ff <= desc_now;
      end
      if (cmd.out_load) begin
         kind_ff <= res_kind;
         char_ff <= res_char;
         num_ff <= res_num;
         last_ff <= res_last;
      end
   end

   assign stat.now_count = desc_now.count;
   assign stat.lat_count = desc_ff.count;
   assign stat.out_free = !valid_ff || rsp_ready;

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_character = char_ff;
   assign rsp_line_number = num_ff;
   assign rsp_last = last_ff;

endmodule

FILE: design/bpd_ctrl.sv
// Controller: accepts input bytes and sequences the result beats of each byte.
module bpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpd_pkg::stat_type stat,
   output bpd_pkg::cmd_type  cmd
);

   bpd_pkg::ctrl_state_type state_ff, state_in;
   logic [2:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpd_pkg::CT_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         bpd_pkg::CT_IDLE: begin
            // The first result of a byte goes straight into the output register.
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               if (stat.now_count != 3'd0) begin
                  cmd.out_load = 1'b1;
               end
               if (stat.now_count > 3'd1) begin
                  state_in = bpd_pkg::CT_EMIT;
                  idx_in = 3'd1;
               end
            end
         end
         bpd_pkg::CT_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.use_latched = 1'b1;
               cmd.idx = idx_ff;
               if (idx_ff == stat.lat_count - 3'd1) begin
                  state_in = bpd_pkg::CT_IDLE;
                  idx_in = 3'd0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = bpd_pkg::CT_IDLE;
            idx_in = 3'd0;
         end
      endcase
   end

endmodule

FILE: design/basic_program_detokenizer.sv
// Top level of the BASIC program detokenizer.
// Usage: the req_bus channel carries the raw bytes of a tokenized program file,
// one byte per beat; first marks the load address low byte of a new file and
// restarts the parser. The rsp_bus channel carries results: line starts with
// the line number, text characters, line ends, program end and backward link
// errors; last marks the final beat caused by one input byte.
// Latency: the first result of a byte is registered and appears in the cycle after
// the byte is accepted. Throughput: a byte gives no or one result, a keyword token
// one result per keyword character (one to seven), and a line end followed by a
// backward link error two; the single output register takes one result beat per
// cycle while the receiver does not stall, and a byte is accepted only after all results of the one before are loaded.
// At reset the parser expects the load address low byte and the output is empty.
// When the receiver stalls, the result beat holds and the input is not accepted
// until the output register can take the next result.
module basic_program_detokenizer #(
   parameter int unsigned KEYWORD_COUNT = bpd_pkg::KEYWORD_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   bpd_req_if.sink   req_bus,
   bpd_rsp_if.source rsp_bus
);

   bpd_pkg::cmd_type  cmd;
   bpd_pkg::stat_type stat;

   bpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpd_dp #(
      .KEYWORD_COUNT (KEYWORD_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_bus.data_byte),
      .req_first       (req_bus.first),
      .rsp_ready       (rsp_bus.ready),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_bus.valid),
      .rsp_kind        (rsp_bus.kind),
      .rsp_character   (rsp_bus.character),
      .rsp_line_number (rsp_bus.line_number),
      .rsp_last        (rsp_bus.last)
   );

endmodule
